// ===== rtl/core/complex_symmetric_fir_halfband_decimator_defines.svh =====
// Assertion macros used by the checker file.
`ifndef COMPLEX_SYMMETRIC_FIR_HALFBAND_DECIMATOR_DEFINES_SVH
`define COMPLEX_SYMMETRIC_FIR_HALFBAND_DECIMATOR_DEFINES_SVH

// Same-cycle implication, sampled on aclk, off while in reset.
`define CSFHD_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off while in reset.
`define CSFHD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/csfhd_pkg.sv =====
package csfhd_pkg;

    // Sample and coefficient formats (Q1.15)
    localparam int SAMPLE_W     = 16;
    localparam int COEF_W       = 16;
    localparam int LANE_W       = 16;
    localparam int COEF_WORD_W  = 64;
    localparam int NUM_COEF_WORDS = 4;

    // Delay line and tap layout
    localparam int DEPTH        = 31;
    localparam int NUM_OPS      = 16;
    localparam int FIR_LAST     = 30;
    localparam int FIR_CENTER   = 15;
    localparam int HB_LAST      = 14;
    localparam int HB_CENTER    = 7;
    localparam int HB_PAIRS     = 4;

    // Datapath widths: pre-add, product, accumulator
    localparam int OP_W         = SAMPLE_W + 1;
    localparam int PROD_W       = 2 * OP_W;
    localparam int ACC_W        = PROD_W + 6;
    localparam int GROUP        = 4;
    localparam int NUM_GROUPS   = NUM_OPS / GROUP;
    localparam int FRAC_SHIFT   = COEF_W - 1;

    // Front-to-back queue
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam int CFG_IDX_W    = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE  = 3'd0,
        REG_COEF0 = 3'd1,
        REG_COEF1 = 3'd2,
        REG_COEF2 = 3'd3,
        REG_COEF3 = 3'd4
    } cfg_reg_t;

    typedef enum logic {
        MODE_FIR      = 1'b0,
        MODE_HALFBAND = 1'b1
    } mode_t;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [OP_W-1:0]     op_t;
    typedef logic signed [PROD_W-1:0]   prod_t;
    typedef logic signed [ACC_W-1:0]    acc_t;

    typedef logic [NUM_COEF_WORDS-1:0][COEF_WORD_W-1:0] coef_bank_t;

    // Centre tap gain of one in halfband mode
    localparam op_t UNITY_GAIN = op_t'(1) <<< FRAC_SHIFT;

    // Pre-added tap operands of one item, I and Q
    typedef struct packed {
        op_t [NUM_OPS-1:0] op_i;
        op_t [NUM_OPS-1:0] op_q;
    } op_set_t;

    // Queue port: item present plus its operands
    typedef struct packed {
        logic    valid;
        op_set_t ops;
    } q_entry_t;

endpackage

// ===== rtl/core/csfhd_front.sv =====
module csfhd_front (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // first_i [15:0], first_q [31:16], second_i [47:32], second_q [63:48]
    input  logic [63:0]            s_tdata,
    input  csfhd_pkg::mode_t       mode,
    output csfhd_pkg::q_entry_t    push,
    input  logic                   push_ready
);
    import csfhd_pkg::*;

    sample_t first_i, first_q, second_i, second_q;
    sample_t line_i_reg  [DEPTH];
    sample_t line_q_reg  [DEPTH];
    sample_t line_i_next [DEPTH];
    sample_t line_q_next [DEPTH];
    sample_t fresh_i [DEPTH];
    sample_t fresh_q [DEPTH];
    logic    accept;

    assign first_i  = s_tdata[SAMPLE_W-1:0];
    assign first_q  = s_tdata[2*SAMPLE_W-1:SAMPLE_W];
    assign second_i = s_tdata[3*SAMPLE_W-1:2*SAMPLE_W];
    assign second_q = s_tdata[4*SAMPLE_W-1:3*SAMPLE_W];

    assign s_tready = push_ready;
    assign accept   = s_tvalid && push_ready;

    // Delay line after the first sample is shifted in
    always_comb begin
        fresh_i[0] = first_i;
        fresh_q[0] = first_q;
        for (int j = 1; j < DEPTH; j++) begin
            fresh_i[j] = line_i_reg[j-1];
            fresh_q[j] = line_q_reg[j-1];
        end
    end

    // Symmetric pre-adds; unused operands are zero
    always_comb begin
        push.valid = accept;
        push.ops   = '0;
        if (mode == MODE_FIR) begin
            for (int k = 0; k < FIR_CENTER; k++) begin
                push.ops.op_i[k] = op_t'(fresh_i[k]) + op_t'(fresh_i[FIR_LAST-k]);
                push.ops.op_q[k] = op_t'(fresh_q[k]) + op_t'(fresh_q[FIR_LAST-k]);
            end
            push.ops.op_i[NUM_OPS-1] = op_t'(fresh_i[FIR_CENTER]);
            push.ops.op_q[NUM_OPS-1] = op_t'(fresh_q[FIR_CENTER]);
        end else begin
            for (int k = 0; k < HB_PAIRS; k++) begin
                push.ops.op_i[k] = op_t'(fresh_i[2*k]) + op_t'(fresh_i[HB_LAST-2*k]);
                push.ops.op_q[k] = op_t'(fresh_q[2*k]) + op_t'(fresh_q[HB_LAST-2*k]);
            end
            push.ops.op_i[NUM_OPS-1] = op_t'(fresh_i[HB_CENTER]);
            push.ops.op_q[NUM_OPS-1] = op_t'(fresh_q[HB_CENTER]);
        end
    end

    // Halfband items also shift in the second sample after the output taps
    always_comb begin
        if (mode == MODE_FIR) begin
            for (int j = 0; j < DEPTH; j++) begin
                line_i_next[j] = fresh_i[j];
                line_q_next[j] = fresh_q[j];
            end
        end else begin
            line_i_next[0] = second_i;
            line_q_next[0] = second_q;
            for (int j = 1; j < DEPTH; j++) begin
                line_i_next[j] = fresh_i[j-1];
                line_q_next[j] = fresh_q[j-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < DEPTH; j++) begin
                line_i_reg[j] <= '0;
                line_q_reg[j] <= '0;
            end
        end else if (accept) begin
            line_i_reg <= line_i_next;
            line_q_reg <= line_q_next;
        end
    end

endmodule

// ===== rtl/core/csfhd_queue.sv =====
module csfhd_queue (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  csfhd_pkg::q_entry_t    push,
    output logic                   push_ready,
    output csfhd_pkg::q_entry_t    pop,
    input  logic                   pop_ready
);
    import csfhd_pkg::*;

    op_set_t           entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_push, do_pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop.valid  = (count_reg != '0);
    assign pop.ops    = entry_reg[rd_ptr_reg];

    assign do_push = push.valid && push_ready;
    assign do_pop  = pop.valid && pop_ready;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        ptr_inc = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // Pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            if (do_pop)  rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            if (do_push && !do_pop)      count_reg <= count_reg + 1'b1;
            else if (!do_push && do_pop) count_reg <= count_reg - 1'b1;
        end
    end

    // Entry storage
    always_ff @(posedge aclk) begin
        if (do_push) entry_reg[wr_ptr_reg] <= push.ops;
    end

endmodule

// ===== rtl/core/csfhd_back.sv =====
module csfhd_back (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  csfhd_pkg::q_entry_t    pop,
    output logic                   pop_ready,
    input  csfhd_pkg::coef_bank_t  coef_bank,
    input  csfhd_pkg::mode_t       mode,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // out_i [15:0], out_q [31:16]
    output logic [31:0]            m_tdata
);
    import csfhd_pkg::*;

    localparam acc_t SAT_HI = acc_t'((1 << (SAMPLE_W - 1)) - 1);
    localparam acc_t SAT_LO = -SAT_HI - acc_t'(1);
    localparam acc_t ROUND  = acc_t'(1) <<< (FRAC_SHIFT - 1);

    op_t     coef [NUM_OPS];
    prod_t   prod_i_reg [NUM_OPS];
    prod_t   prod_q_reg [NUM_OPS];
    acc_t    part_i_reg [NUM_GROUPS];
    acc_t    part_q_reg [NUM_GROUPS];
    acc_t    part_i_next [NUM_GROUPS];
    acc_t    part_q_next [NUM_GROUPS];
    acc_t    total_i_reg, total_q_reg, total_i_next, total_q_next;
    sample_t out_i_reg, out_q_reg, out_i_next, out_q_next;
    logic    v1_reg, v2_reg, v3_reg, out_valid_reg;
    logic    adv;

    // Whole pipeline moves unless a finished result is held
    assign adv       = !out_valid_reg || m_tready;
    assign pop_ready = adv;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {out_q_reg, out_i_reg};

    // Coefficient per operand; halfband centre has unity gain
    always_comb begin
        for (int k = 0; k < NUM_OPS; k++) begin
            coef[k] = op_t'($signed(coef_bank[k >> 2][(k & 3) * LANE_W +: COEF_W]));
        end
        if (mode == MODE_HALFBAND) coef[NUM_OPS-1] = UNITY_GAIN;
    end

    // Adder tree, four then four
    always_comb begin
        for (int g = 0; g < NUM_GROUPS; g++) begin
            part_i_next[g] = '0;
            part_q_next[g] = '0;
            for (int m = 0; m < GROUP; m++) begin
                part_i_next[g] = part_i_next[g] + acc_t'(prod_i_reg[g*GROUP+m]);
                part_q_next[g] = part_q_next[g] + acc_t'(prod_q_reg[g*GROUP+m]);
            end
        end
        total_i_next = '0;
        total_q_next = '0;
        for (int g = 0; g < NUM_GROUPS; g++) begin
            total_i_next = total_i_next + part_i_reg[g];
            total_q_next = total_q_next + part_q_reg[g];
        end
    end

    // Round half up and saturate
    function automatic sample_t round_sat(input acc_t acc);
        acc_t s;
        s = (acc + ROUND) >>> FRAC_SHIFT;
        if (s > SAT_HI)      round_sat = sample_t'(SAT_HI);
        else if (s < SAT_LO) round_sat = sample_t'(SAT_LO);
        else                 round_sat = sample_t'(s);
    endfunction

    assign out_i_next = round_sat(total_i_reg);
    assign out_q_next = round_sat(total_q_reg);

    // Stage valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            v1_reg        <= pop.valid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            out_valid_reg <= v3_reg;
        end
    end

    // Stage payloads: products, partial sums, totals, result
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k < NUM_OPS; k++) begin
                prod_i_reg[k] <= $signed(pop.ops.op_i[k]) * coef[k];
                prod_q_reg[k] <= $signed(pop.ops.op_q[k]) * coef[k];
            end
            part_i_reg  <= part_i_next;
            part_q_reg  <= part_q_next;
            total_i_reg <= total_i_next;
            total_q_reg <= total_q_next;
            out_i_reg   <= out_i_next;
            out_q_reg   <= out_q_next;
        end
    end

endmodule

// ===== rtl/core/complex_symmetric_fir_halfband_decimator.sv =====
// Complex I/Q filter with real Q1.15 coefficients. Mode 0 is a 31-tap
// symmetric FIR (one sample in, one out); mode 1 is a 15-tap halfband
// decimator where each item carries two samples and yields one output.
// Register 0 selects the mode, registers 1..4 hold coefficient slots
// 0..15, four 16-bit lanes per word, lowest slot in the low lane; write
// them only while the block is idle. The block takes one item per clock
// while not stalled; an accepted item passes through the queue, then the
// multiply stage and two registered adder-tree stages ahead of the
// rounded result register in the back end, and leaves on m_tdata.
// A result held by m_tready low stalls the whole back end; the two-entry
// queue between front and back then fills and s_tready drops.
// Outputs are rounded half up and saturated to Q1.15. The delay line is
// cleared by reset.
module complex_symmetric_fir_halfband_decimator (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // first_i [15:0], first_q [31:16], second_i [47:32], second_q [63:48]
    input  logic [63:0]                      s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // out_i [15:0], out_q [31:16]
    output logic [31:0]                      m_tdata,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [csfhd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [csfhd_pkg::COEF_WORD_W-1:0] cfg_data
);
    import csfhd_pkg::*;

    mode_t      mode_reg;
    coef_bank_t coef_reg;
    q_entry_t   push, pop;
    logic       push_ready, pop_ready;

    assign cfg_ready = 1'b1;

    // Register file; indexes past the list are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_FIR;
            coef_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_MODE:  mode_reg    <= mode_t'(cfg_data[0]);
                REG_COEF0: coef_reg[0] <= cfg_data;
                REG_COEF1: coef_reg[1] <= cfg_data;
                REG_COEF2: coef_reg[2] <= cfg_data;
                REG_COEF3: coef_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    csfhd_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .mode       (mode_reg),
        .push       (push),
        .push_ready (push_ready)
    );

    csfhd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_ready (push_ready),
        .pop        (pop),
        .pop_ready  (pop_ready)
    );

    csfhd_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .pop        (pop),
        .pop_ready  (pop_ready),
        .coef_bank  (coef_reg),
        .mode       (mode_reg),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

// ===== rtl/core/csfhd_checker.sv =====
`include "complex_symmetric_fir_halfband_decimator_defines.svh"

module csfhd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);
    // Queue entries plus pipeline slots
    localparam int CAP = 6;

    logic [3:0] inflight_reg;
    logic       in_acc, out_acc;

    assign in_acc  = s_tvalid && s_tready;
    assign out_acc = m_tvalid && m_tready;

    // Items accepted but not yet delivered
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inflight_reg <= '0;
        end else if (in_acc && !out_acc) begin
            inflight_reg <= inflight_reg + 1'b1;
        end else if (!in_acc && out_acc) begin
            inflight_reg <= inflight_reg - 1'b1;
        end
    end

    `CSFHD_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
    `CSFHD_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata), "result changed while stalled")
    `CSFHD_ASSERT_IMPL(a_no_phantom, m_tvalid, inflight_reg != 4'd0, "result without an accepted item")
    `CSFHD_ASSERT_IMPL(a_bounded, 1'b1, inflight_reg <= 4'(CAP), "more items in flight than storage")

endmodule

bind complex_symmetric_fir_halfband_decimator csfhd_checker u_csfhd_checker (.*);

// ===== tb/sv/complex_symmetric_fir_halfband_decimator_tb.sv =====
module complex_symmetric_fir_halfband_decimator_tb;
    import csfhd_pkg::*;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int RAND_PHASES     = 10;
    localparam int ITEMS_PER_PHASE = 68;
    localparam int DRAIN_CYCLES    = 20;
    localparam int MAX_IDLE        = 9;
    localparam int SMALL_COEF      = 2048;
    localparam int SLOTS_PER_WORD  = COEF_WORD_W / LANE_W;

    localparam sample_t SAMPLE_TOP    = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam sample_t SAMPLE_BOTTOM = {1'b1, {(SAMPLE_W-1){1'b0}}};
    localparam logic [COEF_W-1:0] COEF_TOP    = {1'b0, {(COEF_W-1){1'b1}}};
    localparam logic [COEF_W-1:0] COEF_BOTTOM = {1'b1, {(COEF_W-1){1'b0}}};

    // register indexes past the last coefficient word decode to nothing
    localparam logic [CFG_IDX_W-1:0] IDX_UNMAPPED_FIRST = CFG_IDX_W'(REG_COEF3 + 1);
    localparam logic [CFG_IDX_W-1:0] IDX_UNMAPPED_LAST  = '1;

    // input item, first_i in the low bits
    typedef struct packed {
        sample_t second_q;
        sample_t second_i;
        sample_t first_q;
        sample_t first_i;
    } iq_pair_t;

    // result item, out_i in the low bits
    typedef struct packed {
        sample_t out_q;
        sample_t out_i;
    } iq_out_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [63:0]            s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [31:0]            m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [COEF_WORD_W-1:0] cfg_data  = '0;

    // filter state as the block should hold it
    sample_t tap_i [DEPTH] = '{default: '0};
    sample_t tap_q [DEPTH] = '{default: '0};
    mode_t filter_mode = MODE_FIR;
    logic [COEF_WORD_W-1:0] coef_word [NUM_COEF_WORDS] = '{default: '0};

    iq_pair_t samples_to_send [$];
    iq_out_t  filtered_due [$];
    int items_queued = 0;
    int items_taken  = 0;
    int fail_count   = 0;
    int cycle_count  = 0;
    int unsigned send_idle_max  = 0;
    int unsigned recv_stall_max = 0;
    int unsigned send_wait  = 0;
    int unsigned recv_stall = 0;

    complex_symmetric_fir_halfband_decimator dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 aclk = ~aclk;

    function automatic longint coef_slot(input int k);
        logic [COEF_WORD_W-1:0] w;
        logic signed [COEF_W-1:0] lane;
        w = coef_word[k / SLOTS_PER_WORD];
        lane = w[(k % SLOTS_PER_WORD) * LANE_W +: COEF_W];
        return longint'(lane);
    endfunction

    // round half up at the Q1.15 point, then clamp
    function automatic sample_t round_sat(input longint acc);
        longint r;
        r = (acc + (longint'(1) <<< (FRAC_SHIFT - 1))) >>> FRAC_SHIFT;
        if (r > longint'(SAMPLE_TOP))
            r = longint'(SAMPLE_TOP);
        else if (r < longint'(SAMPLE_BOTTOM))
            r = longint'(SAMPLE_BOTTOM);
        return sample_t'(r);
    endfunction

    function automatic void shift_in_sample(input sample_t si, input sample_t sq);
        for (int n = DEPTH - 1; n > 0; n--) begin
            tap_i[n] = tap_i[n-1];
            tap_q[n] = tap_q[n-1];
        end
        tap_i[0] = si;
        tap_q[0] = sq;
    endfunction

    // one accepted item in, one filtered sample expected out
    task automatic filter_sample(input iq_pair_t item);
        longint acc_i, acc_q, c;
        iq_out_t res;
        shift_in_sample(item.first_i, item.first_q);
        acc_i = 0;
        acc_q = 0;
        if (filter_mode == MODE_FIR) begin
            for (int k = 0; k < FIR_CENTER; k++) begin
                c = coef_slot(k);
                acc_i += c * (longint'(tap_i[k]) + longint'(tap_i[FIR_LAST - k]));
                acc_q += c * (longint'(tap_q[k]) + longint'(tap_q[FIR_LAST - k]));
            end
            c = coef_slot(FIR_CENTER);
            acc_i += c * longint'(tap_i[FIR_CENTER]);
            acc_q += c * longint'(tap_q[FIR_CENTER]);
        end else begin
            for (int k = 0; k < HB_PAIRS; k++) begin
                c = coef_slot(k);
                acc_i += c * (longint'(tap_i[2*k]) + longint'(tap_i[HB_LAST - 2*k]));
                acc_q += c * (longint'(tap_q[2*k]) + longint'(tap_q[HB_LAST - 2*k]));
            end
            // centre tap has unity gain
            acc_i += longint'(tap_i[HB_CENTER]) <<< FRAC_SHIFT;
            acc_q += longint'(tap_q[HB_CENTER]) <<< FRAC_SHIFT;
        end
        res.out_i = round_sat(acc_i);
        res.out_q = round_sat(acc_q);
        filtered_due.push_back(res);
        // halfband: second sample only enters the line after the output
        if (filter_mode == MODE_HALFBAND)
            shift_in_sample(item.second_i, item.second_q);
    endtask

    task automatic check_field(input string field, input sample_t want, input sample_t got);
        if (got !== want) begin
            fail_count++;
            $error("%s: expected %0d, got %0d", field, want, got);
        end
    endtask

    // register write; only called while nothing is in flight
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [COEF_WORD_W-1:0] value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_MODE: filter_mode = mode_t'(value[0]);
            REG_COEF0, REG_COEF1, REG_COEF2, REG_COEF3: coef_word[idx - REG_COEF0] = value;
            default: ;
        endcase
    endtask

    task automatic queue_item(input sample_t fi, input sample_t fq,
                              input sample_t si, input sample_t sq);
        iq_pair_t it;
        it.first_i  = fi;
        it.first_q  = fq;
        it.second_i = si;
        it.second_q = sq;
        samples_to_send.push_back(it);
        items_queued++;
    endtask

    task automatic wait_drained();
        do @(negedge aclk); while (items_taken != items_queued || filtered_due.size() != 0);
    endtask

    function automatic logic [COEF_WORD_W-1:0] fill_lanes(input logic [COEF_W-1:0] lane);
        return {SLOTS_PER_WORD{lane}};
    endfunction

    // mostly filter-like small taps, sometimes full-scale or raw bits
    function automatic logic [COEF_WORD_W-1:0] pick_coef_word();
        logic [COEF_WORD_W-1:0] w;
        case ($urandom_range(0, 7))
            0: w = fill_lanes(COEF_TOP);
            1: w = fill_lanes(COEF_BOTTOM);
            2: w = {$urandom, $urandom};
            default: begin
                for (int n = 0; n < SLOTS_PER_WORD; n++)
                    w[n*LANE_W +: LANE_W] =
                        LANE_W'($urandom_range(0, 2 * SMALL_COEF) - SMALL_COEF);
            end
        endcase
        return w;
    endfunction

    function automatic sample_t pick_sample();
        case ($urandom_range(0, 9))
            0: return SAMPLE_TOP;
            1: return SAMPLE_BOTTOM;
            2: return '0;
            default: return sample_t'($urandom);
        endcase
    endfunction

    // input side: predict on accept, then gap or present the next item
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid  <= 1'b0;
            send_wait <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                filter_sample(s_tdata);
                items_taken++;
            end
            if (!s_tvalid || s_tready) begin
                if (send_wait != 0) begin
                    send_wait <= send_wait - 1;
                    s_tvalid  <= 1'b0;
                end else if (samples_to_send.size() != 0) begin
                    s_tdata   <= samples_to_send.pop_front();
                    s_tvalid  <= 1'b1;
                    send_wait <= $urandom_range(0, send_idle_max);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result side: compare against the oldest prediction, then stall
    always @(posedge aclk) begin : watch_results
        iq_out_t got, want;
        int unsigned hold;
        if (!aresetn) begin
            m_tready   <= 1'b0;
            recv_stall <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (filtered_due.size() == 0) begin
                    fail_count++;
                    $error("result %h arrived with nothing expected", m_tdata);
                end else begin
                    want = filtered_due.pop_front();
                    check_field("out_i", want.out_i, got.out_i);
                    check_field("out_q", want.out_q, got.out_q);
                end
                hold = $urandom_range(0, recv_stall_max);
                recv_stall <= hold;
                m_tready   <= (hold == 0);
            end else if (recv_stall != 0) begin
                recv_stall <= recv_stall - 1;
                m_tready   <= (recv_stall == 1);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL complex_symmetric_fir_halfband_decimator");
            $finish;
        end
    end

    initial begin
        logic [COEF_WORD_W-1:0] mode_word;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings: zero taps give zero output
        @(negedge aclk);
        queue_item(SAMPLE_TOP, SAMPLE_BOTTOM, SAMPLE_TOP, SAMPLE_BOTTOM);
        queue_item(SAMPLE_BOTTOM, SAMPLE_TOP, SAMPLE_BOTTOM, SAMPLE_TOP);
        wait_drained();

        // FIR, all taps full-scale positive: saturate both ways,
        // second sample must be ignored
        write_reg(REG_MODE, MODE_FIR);
        for (int w = 0; w < NUM_COEF_WORDS; w++)
            write_reg(cfg_reg_t'(REG_COEF0 + w), fill_lanes(COEF_TOP));
        send_idle_max  = MAX_IDLE;
        recv_stall_max = MAX_IDLE;
        @(negedge aclk);
        repeat (6) queue_item(SAMPLE_TOP, SAMPLE_BOTTOM, SAMPLE_BOTTOM, SAMPLE_TOP);
        repeat (6) queue_item(SAMPLE_BOTTOM, SAMPLE_TOP, SAMPLE_TOP, SAMPLE_BOTTOM);
        queue_item('0, '0, SAMPLE_TOP, SAMPLE_TOP);
        queue_item(sample_t'(1), -sample_t'(1), '0, '0);
        wait_drained();

        // halfband via a mode word with junk upper bits; taps full-scale
        // negative; writes to unmapped indexes must change nothing;
        // delay line carries over from FIR mode
        write_reg(REG_MODE, '1);
        write_reg(REG_COEF0, fill_lanes(COEF_BOTTOM));
        write_reg(IDX_UNMAPPED_FIRST, '0);
        write_reg(IDX_UNMAPPED_LAST, '1);
        send_idle_max  = 0;
        recv_stall_max = 0;
        @(negedge aclk);
        repeat (3) queue_item(SAMPLE_TOP, SAMPLE_TOP, SAMPLE_BOTTOM, SAMPLE_BOTTOM);
        repeat (2) queue_item(SAMPLE_BOTTOM, SAMPLE_TOP, SAMPLE_TOP, SAMPLE_BOTTOM);
        queue_item('0, '0, sample_t'(1), -sample_t'(1));
        wait_drained();

        // random settings per phase; each phase drains before the next
        for (int p = 0; p < RAND_PHASES; p++) begin
            mode_word = {$urandom, $urandom};
            mode_word[0] = (p % 2 != 0);
            if (p < 2 || $urandom_range(0, 3) != 0)
                write_reg(REG_MODE, mode_word);
            for (int w = 0; w < NUM_COEF_WORDS; w++)
                if (p == 0 || $urandom_range(0, 3) != 0)
                    write_reg(cfg_reg_t'(REG_COEF0 + w), pick_coef_word());
            if ($urandom_range(0, 3) == 0)
                write_reg(CFG_IDX_W'($urandom_range(IDX_UNMAPPED_FIRST, IDX_UNMAPPED_LAST)),
                          {$urandom, $urandom});
            send_idle_max  = (p % 3 == 0) ? 0 : MAX_IDLE;
            recv_stall_max = (p % 4 == 1) ? 0 : MAX_IDLE;
            @(negedge aclk);
            repeat (ITEMS_PER_PHASE)
                queue_item(pick_sample(), pick_sample(), pick_sample(), pick_sample());
            wait_drained();
        end

        // catch any stray results after the last expected one
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("PASS complex_symmetric_fir_halfband_decimator");
        else
            $display("FAIL complex_symmetric_fir_halfband_decimator");
        $finish;
    end

endmodule
